/* design/adcdb_pkg.sv */
// Shared types, constants and register indexes of the ADC deadband change reporter.
package adcdb_pkg;

  localparam int CHANNELS    = 5;
  localparam int SAMPLE_BITS = 10;
  localparam int PORT_BITS   = 8;
  localparam int PORTS       = 3;
  localparam int DB_BITS     = 10;
  localparam int CEIL_BITS   = 11;
  localparam int TRIG_BITS   = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 11;

  // Pins that exist on each port.
  localparam logic [PORT_BITS-1:0] AVAIL_P1 = 8'h1F;
  localparam logic [PORT_BITS-1:0] AVAIL_P2 = 8'hF8;
  localparam logic [PORT_BITS-1:0] AVAIL_P3 = 8'hF8;

  // Register reset values.
  localparam logic [CHANNELS-1:0]  RST_ANALOG_EN = 5'd4;
  localparam logic [PORT_BITS-1:0] RST_P1_OUT    = 8'd3;
  localparam logic [PORT_BITS-1:0] RST_P2_OUT    = 8'd0;
  localparam logic [PORT_BITS-1:0] RST_P3_OUT    = 8'd0;
  localparam logic [DB_BITS-1:0]   RST_DEADBAND  = 10'd15;
  localparam logic [CEIL_BITS-1:0] RST_CEILING   = 11'd750;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_ANALOG_EN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_P1_OUT    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_P2_OUT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_P3_OUT    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CEILING   = 3'd5;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample0;
    logic [SAMPLE_BITS-1:0] sample1;
    logic [SAMPLE_BITS-1:0] sample2;
    logic [SAMPLE_BITS-1:0] sample3;
    logic [SAMPLE_BITS-1:0] sample4;
    logic [PORT_BITS-1:0]   port1_pins;
    logic [PORT_BITS-1:0]   port2_pins;
    logic [PORT_BITS-1:0]   port3_pins;
    logic                   host_request;
  } scan_in_t;

  typedef struct packed {
    logic [TRIG_BITS-1:0] trigger_flags;
    logic [PORT_BITS-1:0] port1_state;
    logic [PORT_BITS-1:0] port2_state;
    logic [PORT_BITS-1:0] port3_state;
    logic                 discard_mark;
    logic                 notify_host;
  } scan_out_t;

  // What the lanes found for one scan, handed to the merge stage.
  typedef struct packed {
    logic [CHANNELS-1:0] lane_fire;
    logic [PORTS-1:0]    port_change;
    logic                first_scan;
    logic                host_request;
  } scan_flags_t;

endpackage

/* design/adcdb_lane.sv */
// One analog channel lane: deadband compare against its stored last value.
module adcdb_lane
  import adcdb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   update,
  input  logic                   enable,
  input  logic [CEIL_BITS-1:0]   ceiling,
  input  logic [DB_BITS-1:0]     deadband,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   fire
);

  localparam int DW = SAMPLE_BITS + 2;

  logic [SAMPLE_BITS-1:0] last_r;
  logic [SAMPLE_BITS-1:0] last_nxt;
  logic signed [DW-1:0]   diff;
  logic signed [DW-1:0]   db_s;
  logic                   in_range;

  always_comb begin
    in_range = ({{(DW-SAMPLE_BITS){1'b0}}, sample} < {{(DW-CEIL_BITS){1'b0}}, ceiling});
    diff     = signed'({2'b00, sample}) - signed'({2'b00, last_r});
    db_s     = signed'({{(DW-DB_BITS){1'b0}}, deadband});
    fire     = enable && in_range && ((diff > db_s) || (-diff > db_s));
    last_nxt = (update && fire) ? sample : last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else begin
      last_r <= last_nxt;
    end
  end

endmodule

/* design/adcdb_port.sv */
// One port lane: masks the raw pins and flags a change against the stored value.
module adcdb_port
  import adcdb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 update,
  input  logic [PORT_BITS-1:0] pins,
  input  logic [PORT_BITS-1:0] watch_mask,
  output logic [PORT_BITS-1:0] state,
  output logic                 change
);

  logic [PORT_BITS-1:0] last_r;
  logic [PORT_BITS-1:0] last_nxt;

  always_comb begin
    state    = pins & watch_mask;
    change   = (state != last_r);
    last_nxt = update ? state : last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else begin
      last_r <= last_nxt;
    end
  end

endmodule

/* design/adcdb_merge.sv */
// Merge stage: folds lane and port findings into one result word.
module adcdb_merge
  import adcdb_pkg::*;
(
  input  scan_flags_t          flags,
  input  logic [PORT_BITS-1:0] p1_state,
  input  logic [PORT_BITS-1:0] p2_state,
  input  logic [PORT_BITS-1:0] p3_state,
  output scan_out_t            result
);

  logic [TRIG_BITS-1:0] trig;

  always_comb begin
    trig = {flags.port_change, (|flags.lane_fire) | flags.first_scan};
    result.trigger_flags = trig;
    result.port1_state   = p1_state;
    result.port2_state   = p2_state;
    result.port3_state   = p3_state;
    result.discard_mark  = flags.host_request && (trig == '0);
    result.notify_host   = flags.host_request || (trig != '0);
  end

endmodule

/* design/adc_deadband_change_reporter.sv */
// Top level of the ADC deadband change reporter: config, lanes, merge and output buffer.
//
// Usage: each input word on in_data is one scan (five converter samples, three
// port pin snapshots and the host request flag), handed over with in_valid and
// in_ready. Every accepted scan yields exactly one result word on out_data with
// out_valid and out_ready, in order.
// Five channel lanes and three port lanes judge the scan side by side in the
// cycle it is accepted; the merge stage forms the result, which is registered.
// Each result goes to the output register, or to the skid register while one waits.
// One scan per cycle while in_ready is high; compare and last-value update coincide.
// The output side has a two-word buffer (output register plus skid register),
// so a scan can still be taken while one result waits; in_ready drops only when
// both are full, and rises again as soon as out_ready drains one word.
// Reset (rst_n, synchronous, active low) loads the register defaults, clears
// the stored samples and port values, empties the buffer and arms the
// first-scan flag, so the first scan afterwards always reports an analog
// trigger. Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at
// the clock edge; indexes beyond the register list are ignored.
module adc_deadband_change_reporter
  import adcdb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  scan_in_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output scan_out_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  // Configuration registers.
  logic [CHANNELS-1:0]  analog_en_r;
  logic [PORT_BITS-1:0] p1_out_r;
  logic [PORT_BITS-1:0] p2_out_r;
  logic [PORT_BITS-1:0] p3_out_r;
  logic [DB_BITS-1:0]   deadband_r;
  logic [CEIL_BITS-1:0] ceiling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      analog_en_r <= RST_ANALOG_EN;
      p1_out_r    <= RST_P1_OUT;
      p2_out_r    <= RST_P2_OUT;
      p3_out_r    <= RST_P3_OUT;
      deadband_r  <= RST_DEADBAND;
      ceiling_r   <= RST_CEILING;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANALOG_EN: analog_en_r <= cfg_wdata[CHANNELS-1:0];
        REG_P1_OUT:    p1_out_r    <= cfg_wdata[PORT_BITS-1:0];
        REG_P2_OUT:    p2_out_r    <= cfg_wdata[PORT_BITS-1:0];
        REG_P3_OUT:    p3_out_r    <= cfg_wdata[PORT_BITS-1:0];
        REG_DEADBAND:  deadband_r  <= cfg_wdata[DB_BITS-1:0];
        REG_CEILING:   ceiling_r   <= cfg_wdata[CEIL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: a scan is taken whenever the skid register is free.
  logic push;
  logic pop;
  logic out_valid_r;
  logic skid_valid_r;

  assign in_ready = !skid_valid_r;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  // Channel lanes.
  logic [SAMPLE_BITS-1:0] samples [CHANNELS];
  logic [CHANNELS-1:0]    lane_fire;

  assign samples[0] = in_data.sample0;
  assign samples[1] = in_data.sample1;
  assign samples[2] = in_data.sample2;
  assign samples[3] = in_data.sample3;
  assign samples[4] = in_data.sample4;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    adcdb_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .update   (push),
      .enable   (analog_en_r[g]),
      .ceiling  (ceiling_r),
      .deadband (deadband_r),
      .sample   (samples[g]),
      .fire     (lane_fire[g])
    );
  end

  // Port lanes. Port one also drops pins used as analog inputs.
  logic [PORT_BITS-1:0] p1_watch;
  logic [PORT_BITS-1:0] p2_watch;
  logic [PORT_BITS-1:0] p3_watch;
  logic [PORT_BITS-1:0] p1_state;
  logic [PORT_BITS-1:0] p2_state;
  logic [PORT_BITS-1:0] p3_state;
  logic [PORTS-1:0]     port_change;

  assign p1_watch = AVAIL_P1 & ~p1_out_r & ~{{(PORT_BITS-CHANNELS){1'b0}}, analog_en_r};
  assign p2_watch = AVAIL_P2 & ~p2_out_r;
  assign p3_watch = AVAIL_P3 & ~p3_out_r;

  adcdb_port u_port1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .update     (push),
    .pins       (in_data.port1_pins),
    .watch_mask (p1_watch),
    .state      (p1_state),
    .change     (port_change[0])
  );

  adcdb_port u_port2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .update     (push),
    .pins       (in_data.port2_pins),
    .watch_mask (p2_watch),
    .state      (p2_state),
    .change     (port_change[1])
  );

  adcdb_port u_port3 (
    .clk        (clk),
    .rst_n      (rst_n),
    .update     (push),
    .pins       (in_data.port3_pins),
    .watch_mask (p3_watch),
    .state      (p3_state),
    .change     (port_change[2])
  );

  // The first accepted scan after reset always reports an analog trigger.
  logic first_scan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_scan_r <= 1'b1;
    end else if (push) begin
      first_scan_r <= 1'b0;
    end
  end

  // Merge stage.
  scan_flags_t flags;
  scan_out_t   result;

  always_comb begin
    flags.lane_fire    = lane_fire;
    flags.port_change  = port_change;
    flags.first_scan   = first_scan_r;
    flags.host_request = in_data.host_request;
  end

  adcdb_merge u_merge (
    .flags    (flags),
    .p1_state (p1_state),
    .p2_state (p2_state),
    .p3_state (p3_state),
    .result   (result)
  );

  // Output register plus skid register. The skid word is always the older
  // one when both would move, so order is kept.
  scan_out_t out_r;
  scan_out_t skid_r;
  logic      out_free;

  assign out_free = !out_valid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (push) begin
          skid_r <= result;
        end
      end else if (push) begin
        out_r <= result;
      end
    end else if (push) begin
      skid_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The skid register only fills behind a held output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word present without an output word");

  // The first scan after reset must report the analog trigger.
  a_first_scan_trig: assert property (@(posedge clk) disable iff (!rst_n)
    (push && first_scan_r) |-> result.trigger_flags[0])
    else $error("first scan did not raise the analog trigger");

  // Accepting a scan clears the first-scan flag.
  a_first_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !first_scan_r)
    else $error("first-scan flag survived an accepted scan");

  // A discard mark always comes with a host notification and no trigger.
  a_discard_notify: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.discard_mark) |->
      (out_r.notify_host && (out_r.trigger_flags == '0)))
    else $error("discard mark inconsistent with trigger and notify flags");

endmodule
